@@ design/evdp_pkg.sv @@
// Shared constants, control/status types and register codes for the extremal vertex core.
package evdp_pkg;

    localparam int MAX_DIM    = 32;
    localparam int VALUE_BITS = 32;

    // field widths of the channels
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int NUM_W   = 16;
    localparam int DIM_W   = 6;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EDIM_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W0  = (DIM_W > EDIM_W) ? DIM_W : EDIM_W;
    localparam int CMP_W1  = (CMP_W0 > POS_W) ? CMP_W0 : POS_W;
    localparam int CMP_W   = (CMP_W1 > ADDR_W) ? CMP_W1 + 1 : ADDR_W + 1;
    localparam int PROD_W  = 2 * VALUE_BITS;

    localparam int COEF_DEPTH = 1 << ADDR_W;
    localparam int VERT_DEPTH = 2 << ADDR_W;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_IN_USE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_NEAREST = CFG_IDX_W'(1);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(32);

    typedef struct packed {
        logic load_coef;
        logic load_coord;
        logic mul;
        logic acc;
        logic decide;
        logic emit_rd;
        logic emit_next;
        logic emit_done;
    } evdp_cmd_t;

    typedef struct packed {
        logic op_coord;
        logic pos_ok;
        logic vertex_last;
        logic set_final;
        logic emit_last;
    } evdp_stat_t;

endpackage

@@ design/evdp_if.sv @@
// Channel interfaces: input items, result items and the configuration write port.
interface evdp_in_if;
    logic                               valid;
    logic                               ready;
    logic                               op;
    logic [evdp_pkg::POS_W-1:0]         position;
    logic signed [evdp_pkg::VALUE_W-1:0] value;
    logic                               final_vertex;

    modport source (output valid, op, position, value, final_vertex, input ready);
    modport sink   (input valid, op, position, value, final_vertex, output ready);
endinterface

interface evdp_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [evdp_pkg::VALUE_W-1:0] coordinate;
    logic [evdp_pkg::POS_W-1:0]         coordinate_index;
    logic signed [evdp_pkg::SUM_W-1:0]  extremal_distance;
    logic [evdp_pkg::NUM_W-1:0]         vertex_number;
    logic                               last;

    modport source (output valid, coordinate, coordinate_index, extremal_distance,
                    vertex_number, last, input ready);
    modport sink   (input valid, coordinate, coordinate_index, extremal_distance,
                    vertex_number, last, output ready);
endinterface

interface evdp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [evdp_pkg::CFG_IDX_W-1:0]      index;
    logic [evdp_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/evdp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module evdp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/evdp_datapath.sv @@
// Datapath: config registers, coefficient and vertex RAMs, multiply-accumulate, best-vertex tracking.
module evdp_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  evdp_pkg::evdp_cmd_t                  cmd,
    output evdp_pkg::evdp_stat_t                 stat,
    input  logic                                 cfg_we,
    input  logic [evdp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [evdp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 op,
    input  logic [evdp_pkg::POS_W-1:0]           position,
    input  logic signed [evdp_pkg::VALUE_W-1:0]  value,
    input  logic                                 final_vertex,
    output logic signed [evdp_pkg::VALUE_W-1:0]  coordinate,
    output logic [evdp_pkg::POS_W-1:0]           coordinate_index,
    output logic signed [evdp_pkg::SUM_W-1:0]    extremal_distance,
    output logic [evdp_pkg::NUM_W-1:0]           vertex_number,
    output logic                                 last
);

    // configuration
    logic [evdp_pkg::DIM_W-1:0] dim_reg;
    logic                       nearest_reg;
    logic [evdp_pkg::CMP_W-1:0] dim_ext;
    logic [evdp_pkg::CMP_W-1:0] eff_dim;

    // input side
    logic [evdp_pkg::CMP_W-1:0]  pos_ext;
    logic [evdp_pkg::ADDR_W-1:0] pos_addr;
    logic                        pos_lt_max;

    // per-index bank selects of the two-bank vertex store
    logic [evdp_pkg::MAX_DIM-1:0] cur_sel_reg;
    logic [evdp_pkg::MAX_DIM-1:0] best_sel_reg;

    logic signed [evdp_pkg::VALUE_BITS-1:0] value_reg;
    logic                                   vlast_reg;
    logic                                   fin_reg;
    logic [evdp_pkg::VALUE_BITS-1:0]        coef_rdata;
    logic [evdp_pkg::VALUE_BITS-1:0]        vert_rdata;
    logic signed [evdp_pkg::PROD_W-1:0]     prod_next;
    logic signed [evdp_pkg::PROD_W-1:0]     prod_reg;

    logic signed [evdp_pkg::SUM_W-1:0] sum_reg;
    logic signed [evdp_pkg::SUM_W-1:0] best_dist_reg;
    logic signed [evdp_pkg::SUM_W-1:0] cand_dist;
    logic                              have_best_reg;
    logic                              take;
    logic [evdp_pkg::NUM_W-1:0]        count_reg;
    logic [evdp_pkg::NUM_W-1:0]        best_num_reg;

    logic [evdp_pkg::ADDR_W-1:0] idx_reg;
    logic [evdp_pkg::ADDR_W:0]   vert_waddr;
    logic [evdp_pkg::ADDR_W:0]   vert_raddr;

    assign dim_ext = evdp_pkg::CMP_W'(dim_reg);
    assign eff_dim = (dim_ext == '0) ? evdp_pkg::CMP_W'(1) :
                     (dim_ext > evdp_pkg::CMP_W'(evdp_pkg::MAX_DIM)) ?
                     evdp_pkg::CMP_W'(evdp_pkg::MAX_DIM) : dim_ext;

    assign pos_ext    = evdp_pkg::CMP_W'(position);
    assign pos_addr   = evdp_pkg::ADDR_W'(position);
    assign pos_lt_max = pos_ext < evdp_pkg::CMP_W'(evdp_pkg::MAX_DIM);

    assign stat.op_coord    = op;
    assign stat.pos_ok      = pos_ext < eff_dim;
    assign stat.vertex_last = vlast_reg;
    assign stat.set_final   = fin_reg;
    assign stat.emit_last   = evdp_pkg::CMP_W'(idx_reg) == (eff_dim - evdp_pkg::CMP_W'(1));

    // a coordinate goes to the bank not holding the best copy of that index
    assign vert_waddr = {~best_sel_reg[pos_addr], pos_addr};
    assign vert_raddr = {best_sel_reg[idx_reg], idx_reg};

    evdp_ram #(
        .WIDTH (evdp_pkg::VALUE_BITS),
        .DEPTH (evdp_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cmd.load_coef && pos_lt_max),
        .waddr (pos_addr),
        .wdata (value[evdp_pkg::VALUE_BITS-1:0]),
        .re    (cmd.load_coord),
        .raddr (pos_addr),
        .rdata (coef_rdata)
    );

    evdp_ram #(
        .WIDTH (evdp_pkg::VALUE_BITS),
        .DEPTH (evdp_pkg::VERT_DEPTH)
    ) u_vert_ram (
        .clk   (clk),
        .we    (cmd.load_coord),
        .waddr (vert_waddr),
        .wdata (value[evdp_pkg::VALUE_BITS-1:0]),
        .re    (cmd.emit_rd),
        .raddr (vert_raddr),
        .rdata (vert_rdata)
    );

    assign prod_next = $signed(coef_rdata) * value_reg;

    assign cand_dist = -sum_reg;
    always_comb
    begin
        priority if (!have_best_reg)
        begin
            take = 1'b1;
        end
        else if (nearest_reg)
        begin
            take = best_dist_reg > cand_dist;
        end
        else
        begin
            take = cand_dist > best_dist_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_coord)
        begin
            value_reg <= value[evdp_pkg::VALUE_BITS-1:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg       <= evdp_pkg::DIM_RESET;
            nearest_reg   <= 1'b0;
            cur_sel_reg   <= '0;
            best_sel_reg  <= '0;
            vlast_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            sum_reg       <= '0;
            best_dist_reg <= '0;
            have_best_reg <= 1'b0;
            count_reg     <= '0;
            best_num_reg  <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == evdp_pkg::REG_DIM_IN_USE)
                begin
                    dim_reg <= cfg_data[evdp_pkg::DIM_W-1:0];
                end
                else if (cfg_index == evdp_pkg::REG_SELECT_NEAREST)
                begin
                    nearest_reg <= cfg_data[0];
                end
            end
            if (cmd.load_coord)
            begin
                cur_sel_reg[pos_addr] <= ~best_sel_reg[pos_addr];
                vlast_reg <= pos_ext == (eff_dim - evdp_pkg::CMP_W'(1));
                fin_reg   <= final_vertex;
            end
            if (cmd.acc)
            begin
                sum_reg <= sum_reg + evdp_pkg::SUM_W'(prod_reg);
            end
            if (cmd.decide)
            begin
                sum_reg <= '0;
                if (take)
                begin
                    have_best_reg <= 1'b1;
                    best_dist_reg <= cand_dist;
                    best_num_reg  <= count_reg;
                    best_sel_reg  <= cur_sel_reg;
                end
                if (count_reg != '1)
                begin
                    count_reg <= count_reg + evdp_pkg::NUM_W'(1);
                end
            end
            if (cmd.emit_next)
            begin
                idx_reg <= idx_reg + evdp_pkg::ADDR_W'(1);
            end
            if (cmd.emit_done)
            begin
                idx_reg       <= '0;
                have_best_reg <= 1'b0;
                count_reg     <= '0;
                best_num_reg  <= '0;
            end
        end
    end

    assign coordinate        = evdp_pkg::VALUE_W'($signed(vert_rdata));
    assign coordinate_index  = evdp_pkg::POS_W'(idx_reg);
    assign extremal_distance = best_dist_reg;
    assign vertex_number     = best_num_reg;
    assign last              = stat.emit_last;

endmodule

@@ design/evdp_ctrl.sv @@
// Controller: sequences accept, multiply, accumulate, decision and the result run.
module evdp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  evdp_pkg::evdp_stat_t stat,
    output evdp_pkg::evdp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_DIST = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!stat.op_coord)
                    begin
                        cmd.load_coef = 1'b1;
                    end
                    else if (stat.pos_ok)
                    begin
                        cmd.load_coord = 1'b1;
                        state_next     = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = stat.vertex_last ? S_DIST : S_IDLE;
            end
            S_DIST:
            begin
                cmd.decide = 1'b1;
                state_next = stat.set_final ? S_RD : S_IDLE;
            end
            S_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (stat.emit_last)
                    begin
                        cmd.emit_done = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a result beat is pending");

    a_coord_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_coord |=> cmd.mul)
        else $error("coordinate beat not followed by multiply");

    a_mul_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> cmd.acc)
        else $error("multiply not followed by accumulate");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_done |=> (state_reg == S_IDLE))
        else $error("run end did not return to idle");

endmodule

@@ design/extremal_vertex_by_dot_product_core.sv @@
// Top level: extremal vertex search by dot product, controller plus datapath.
//
//  channel   | dir  | beat carries
//  ----------+------+-------------------------------------------------------------
//  in_item   | sink | op, position, value, final_vertex
//  out_item  | src  | coordinate, coordinate_index, extremal_distance, vertex_number, last
//  cfg       | sink | index, data (0: dim_in_use, 1: select_nearest)
//
// Coefficient beat: taken in the idle state. Coordinate beat: RAM read, multiply,
// accumulate, plus the compare against the best on a vertex's last coordinate.
// A final vertex adds a run of results, each a vertex RAM read and an output beat.
// Reset is asynchronous; RAM contents are not cleared and no sweep follows reset.
// in_item.ready is low while an item or a run is in flight; cfg is always ready.
module extremal_vertex_by_dot_product_core (
    input  logic       clk,
    input  logic       rst_n,
    evdp_in_if.sink    in_item,
    evdp_out_if.source out_item,
    evdp_cfg_if.sink   cfg
);

    evdp_pkg::evdp_cmd_t  cmd;
    evdp_pkg::evdp_stat_t stat;

    assign cfg.ready = 1'b1;

    evdp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_item.valid),
        .in_ready  (in_item.ready),
        .out_valid (out_item.valid),
        .out_ready (out_item.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    evdp_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg.valid && cfg.ready),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .op                (in_item.op),
        .position          (in_item.position),
        .value             (in_item.value),
        .final_vertex      (in_item.final_vertex),
        .coordinate        (out_item.coordinate),
        .coordinate_index  (out_item.coordinate_index),
        .extremal_distance (out_item.extremal_distance),
        .vertex_number     (out_item.vertex_number),
        .last              (out_item.last)
    );

endmodule

@@ verif/tb_extremal_vertex_by_dot_product_core.sv @@
// Self-checking testbench for the extremal vertex core: queued stimulus, predictor, beat checker.
`timescale 1ns / 1ps

module tb_extremal_vertex_by_dot_product_core;

    typedef enum logic {
        OP_LOAD_COEF = 1'b0,
        OP_COORD     = 1'b1
    } item_op_t;

    typedef struct packed {
        item_op_t                     op;
        logic [evdp_pkg::POS_W-1:0]   position;
        logic [evdp_pkg::VALUE_W-1:0] value;
        logic                         final_vertex;
    } stream_item_t;

    typedef struct packed {
        logic [evdp_pkg::VALUE_W-1:0] coordinate;
        logic [evdp_pkg::POS_W-1:0]   coordinate_index;
        logic [evdp_pkg::SUM_W-1:0]   extremal_distance;
        logic [evdp_pkg::NUM_W-1:0]   vertex_number;
        logic                         last;
    } extreme_beat_t;

    localparam logic [evdp_pkg::CFG_IDX_W-1:0] REG_SPARE = evdp_pkg::CFG_IDX_W'(9);
    localparam int QUIET_LIMIT = 2000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            drv_valid = 1'b0;
    stream_item_t                    drv_item  = '0;
    logic                            rx_ready  = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [evdp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [evdp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    evdp_in_if  in_if ();
    evdp_out_if out_if ();
    evdp_cfg_if cfg_if ();

    assign in_if.valid        = drv_valid;
    assign in_if.op           = drv_item.op;
    assign in_if.position     = drv_item.position;
    assign in_if.value        = drv_item.value;
    assign in_if.final_vertex = drv_item.final_vertex;
    assign out_if.ready       = rx_ready;
    assign cfg_if.valid       = cfg_valid;
    assign cfg_if.index       = cfg_index;
    assign cfg_if.data        = cfg_data;

    extremal_vertex_by_dot_product_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_if),
        .out_item (out_if),
        .cfg      (cfg_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- predictor state ----------------
    logic signed [evdp_pkg::VALUE_W-1:0] coef_ram [evdp_pkg::MAX_DIM];
    logic signed [evdp_pkg::VALUE_W-1:0] vtx_ram  [evdp_pkg::MAX_DIM];
    logic signed [evdp_pkg::VALUE_W-1:0] best_ram [evdp_pkg::MAX_DIM];
    logic signed [evdp_pkg::SUM_W-1:0]   acc_sum   = '0;
    logic signed [evdp_pkg::SUM_W-1:0]   best_dist = '0;
    bit                                  have_best = 1'b0;
    logic [evdp_pkg::NUM_W-1:0]          vtx_count = '0;
    logic [evdp_pkg::NUM_W-1:0]          best_num  = '0;
    logic [evdp_pkg::DIM_W-1:0]          dim_reg   = evdp_pkg::DIM_RESET;
    bit                                  nearest_reg = 1'b0;

    extreme_beat_t kept_beats [$];
    stream_item_t  stream_items [$];

    // generator bookkeeping: which entries have been written, where the set stands
    bit          coef_seen [evdp_pkg::MAX_DIM];
    bit          vtx_seen  [evdp_pkg::MAX_DIM];
    bit          set_open     = 1'b0;
    bit          vertex_open  = 1'b0;
    bit          extreme_only = 1'b0;
    int unsigned gen_count    = 0;

    int  fails = 0;
    bit  in_took = 1'b0;
    int  gap_left = 0;
    int  burst_left = 0;
    int  stall_left = 0;
    int  rx_mode = 0;
    int  rx_cycle = 0;
    int  quiet_cycles = 0;

    function automatic int unsigned eff_dim(logic [evdp_pkg::DIM_W-1:0] raw);
        if (raw < 1)
            return 1;
        if (raw > evdp_pkg::MAX_DIM)
            return evdp_pkg::MAX_DIM;
        return 32'(raw);
    endfunction

    function automatic void apply_reg(logic [evdp_pkg::CFG_IDX_W-1:0] idx,
                                      logic [evdp_pkg::CFG_DATA_W-1:0] data);
        if (idx == evdp_pkg::REG_DIM_IN_USE)
            dim_reg = data[evdp_pkg::DIM_W-1:0];
        else if (idx == evdp_pkg::REG_SELECT_NEAREST)
            nearest_reg = data[0];
    endfunction

    // One accepted input beat: accumulate, pick the extremal vertex, emit the run at set end.
    function automatic void advance_search(stream_item_t it);
        int unsigned                       d;
        int unsigned                       i;
        logic signed [evdp_pkg::SUM_W-1:0] lhs;
        logic signed [evdp_pkg::SUM_W-1:0] rhs;
        logic signed [evdp_pkg::SUM_W-1:0] cand_dist;
        bit                                take;
        extreme_beat_t                     b;
        d = eff_dim(dim_reg);
        if (it.op == OP_LOAD_COEF)
        begin
            coef_ram[it.position] = it.value;
            return;
        end
        if (it.position >= d)
            return;
        vtx_ram[it.position] = it.value;
        lhs = coef_ram[it.position];
        rhs = $signed(it.value);
        acc_sum = acc_sum + lhs * rhs;
        if (it.position != d - 1)
            return;
        cand_dist = -acc_sum;
        acc_sum = '0;
        if (!have_best)
            take = 1'b1;
        else if (nearest_reg)
            take = best_dist > cand_dist;
        else
            take = cand_dist > best_dist;
        if (take)
        begin
            have_best = 1'b1;
            best_dist = cand_dist;
            best_num  = vtx_count;
            best_ram  = vtx_ram;
        end
        if (vtx_count != {evdp_pkg::NUM_W{1'b1}})
            vtx_count = vtx_count + evdp_pkg::NUM_W'(1);
        if (!it.final_vertex)
            return;
        for (i = 0; i < d; i++)
        begin
            b.coordinate        = best_ram[i];
            b.coordinate_index  = evdp_pkg::POS_W'(i);
            b.extremal_distance = best_dist;
            b.vertex_number     = best_num;
            b.last              = (i == d - 1);
            kept_beats.push_back(b);
        end
        have_best = 1'b0;
        vtx_count = '0;
        best_num  = '0;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [evdp_pkg::VALUE_W-1:0] pick_value();
        if (extreme_only)
            return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4, 5: return evdp_pkg::VALUE_W'($urandom_range(0, 6)) - evdp_pkg::VALUE_W'(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic void queue_item(item_op_t op, int unsigned p,
                                       logic [evdp_pkg::VALUE_W-1:0] v, logic f);
        stream_item_t it;
        int unsigned  d;
        d = eff_dim(dim_reg);
        it.op           = op;
        it.position     = evdp_pkg::POS_W'(p);
        it.value        = v;
        it.final_vertex = f;
        if (op == OP_LOAD_COEF)
            coef_seen[p] = 1'b1;
        else if (p < d)
        begin
            vtx_seen[p] = 1'b1;
            vertex_open = (p != d - 1);
            if (p == d - 1)
                set_open = !f;
        end
        stream_items.push_back(it);
        gen_count++;
    endfunction

    // A vertex ending on its completing coordinate; a broken one repeats, skips
    // (only entries written before), sends out-of-range positions and reloads coefficients.
    function automatic void gen_vertex(bit fin, bit broken);
        int unsigned d;
        int unsigned p;
        bit          skip;
        d = eff_dim(dim_reg);
        for (p = 0; p < d; p++)
            if (!coef_seen[p])
                queue_item(OP_LOAD_COEF, p, pick_value(), 1'($urandom));
        for (p = 0; p < d; p++)
        begin
            skip = 1'b0;
            if (broken && p != d - 1)
            begin
                case ($urandom_range(0, 5))
                    0: queue_item(OP_COORD, p, pick_value(), 1'($urandom));
                    1: if (d < evdp_pkg::MAX_DIM)
                           queue_item(OP_COORD, $urandom_range(d, evdp_pkg::MAX_DIM - 1),
                                      pick_value(), 1'($urandom));
                    2: queue_item(OP_LOAD_COEF, $urandom_range(0, evdp_pkg::MAX_DIM - 1),
                                  pick_value(), 1'($urandom));
                    default: ;
                endcase
                skip = vtx_seen[p] && ($urandom_range(0, 3) == 0);
            end
            if (!skip)
                queue_item(OP_COORD, p, pick_value(), (p == d - 1) ? fin : 1'($urandom));
        end
    endfunction

    task automatic settle();
        while (stream_items.size() != 0 || drv_valid || kept_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [evdp_pkg::CFG_IDX_W-1:0] idx,
                             logic [evdp_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------- input driver ----------------
    always @(posedge clk)
    begin
        in_took = rst_n && drv_valid && (in_if.ready === 1'b1);
        if (in_took)
            advance_search(drv_item);
    end

    always @(negedge clk)
    begin
        if (rst_n && (!drv_valid || in_took))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                drv_valid <= 1'b0;
            end
            else if (stream_items.size() != 0)
            begin
                drv_item  <= stream_items.pop_front();
                drv_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(0, 8);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                drv_valid <= 1'b0;
            end
        end
    end

    // ---------------- result side ----------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rx_ready <= 1'b0;
        end
        else
        begin
            rx_ready <= 1'b1;
            case (rx_mode)
                1: if ($urandom_range(0, 1) == 0) stall_left = 1;
                2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 24);
                3: stall_left = $urandom_range(0, 2);
                default: ;
            endcase
        end
        rx_cycle++;
        if (rx_cycle % 150 == 0)
            rx_mode = $urandom_range(0, 3);
    end

    always @(posedge clk)
    begin
        extreme_beat_t want;
        if (rst_n && out_if.valid === 1'b1 && rx_ready)
        begin
            if (kept_beats.size() == 0)
            begin
                $error("result beat with nothing pending: coordinate_index %0d",
                       out_if.coordinate_index);
                fails++;
            end
            else
            begin
                want = kept_beats.pop_front();
                check_field("coordinate", $signed(want.coordinate), out_if.coordinate);
                check_field("coordinate_index", want.coordinate_index,
                            out_if.coordinate_index);
                check_field("extremal_distance", want.extremal_distance,
                            out_if.extremal_distance);
                check_field("vertex_number", want.vertex_number, out_if.vertex_number);
                check_field("last", want.last, out_if.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((drv_valid && in_if.ready === 1'b1) || (out_if.valid === 1'b1 && rx_ready) ||
            (cfg_valid && cfg_if.ready === 1'b1))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        int unsigned                ph;
        int unsigned                d;
        int unsigned                nsets;
        int unsigned                nv;
        int unsigned                s;
        int unsigned                v;
        int unsigned                k;
        int unsigned                p;
        bit                         leave;
        logic [evdp_pkg::DIM_W-1:0] raw;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, ties, out-of-range and repeated positions, dim 2, furthest
        write_reg(evdp_pkg::REG_DIM_IN_USE, 8'd2);
        write_reg(evdp_pkg::REG_SELECT_NEAREST, 8'h00);
        queue_item(OP_LOAD_COEF, 0, 32'h7FFF_FFFF, 1'b0);
        queue_item(OP_LOAD_COEF, 1, 32'h8000_0000, 1'b1);
        queue_item(OP_COORD, 0, 32'h8000_0000, 1'b1);   // final ignored mid-vertex
        queue_item(OP_COORD, 1, 32'h8000_0000, 1'b0);
        queue_item(OP_COORD, 7, 32'h0001_2345, 1'b1);   // past dimension, dropped
        queue_item(OP_COORD, 0, 32'h7FFF_FFFF, 1'b0);
        queue_item(OP_COORD, 1, 32'h7FFF_FFFF, 1'b0);
        queue_item(OP_COORD, 0, 32'h7FFF_FFFF, 1'b0);   // tie: earlier vertex stays
        queue_item(OP_COORD, 1, 32'h7FFF_FFFF, 1'b0);
        queue_item(OP_COORD, 0, 32'h0000_0001, 1'b0);
        queue_item(OP_COORD, 0, 32'h0000_0001, 1'b0);   // repeated position adds twice
        queue_item(OP_COORD, 1, 32'h0000_0000, 1'b1);
        settle();

        // nearest; skipped coordinate reuses the stored one, coefficient reload mid-set
        write_reg(evdp_pkg::REG_SELECT_NEAREST, 8'h01);
        queue_item(OP_COORD, 1, 32'h0000_0005, 1'b0);
        queue_item(OP_LOAD_COEF, 1, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_COORD, 0, 32'h8000_0000, 1'b0);
        queue_item(OP_COORD, 1, 32'h7FFF_FFFF, 1'b1);
        settle();

        write_reg(evdp_pkg::REG_DIM_IN_USE, 8'd1);
        queue_item(OP_COORD, 0, 32'hFFFF_FFFD, 1'b0);
        queue_item(OP_COORD, 0, 32'h0000_0003, 1'b0);
        queue_item(OP_COORD, 0, 32'h0000_0003, 1'b1);
        settle();

        // dimension shrinks while a vertex is half delivered
        write_reg(evdp_pkg::REG_DIM_IN_USE, 8'd3);
        queue_item(OP_LOAD_COEF, 2, 32'h0000_0007, 1'b0);
        queue_item(OP_COORD, 0, 32'hFFFF_FFFF, 1'b0);
        queue_item(OP_COORD, 1, 32'h0000_0010, 1'b1);
        settle();
        write_reg(evdp_pkg::REG_DIM_IN_USE, 8'd2);
        queue_item(OP_COORD, 2, 32'h1234_5678, 1'b1);
        queue_item(OP_COORD, 1, 32'h8000_0000, 1'b1);

        // random phases
        ph = 0;
        while (ph < 4 || gen_count < 150)
        begin
            case (ph)
                0: raw = 6'd32;
                1: raw = 6'd0;
                2: raw = 6'd45;
                default: raw = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(9, 32))
                                                           : 6'($urandom_range(1, 8));
            endcase
            // a growing dimension must not meet a half-built set
            if (eff_dim(raw) > eff_dim(dim_reg) && (set_open || vertex_open))
                gen_vertex(1'b1, 1'b0);
            settle();
            write_reg(evdp_pkg::REG_DIM_IN_USE, {2'($urandom), raw});
            write_reg(evdp_pkg::REG_SELECT_NEAREST, {7'($urandom), 1'($urandom)});
            if (ph == 3)
                write_reg(REG_SPARE, 8'($urandom));
            extreme_only = (ph == 0);
            d = eff_dim(dim_reg);
            nsets = (d > 8) ? 1 : $urandom_range(1, 3);
            for (s = 0; s < nsets; s++)
            begin
                nv = (d > 8) ? 1 : $urandom_range(1, 6);
                leave = (s == nsets - 1) && ($urandom_range(0, 3) == 0);
                for (v = 0; v < nv; v++)
                    gen_vertex((v == nv - 1) && !leave, $urandom_range(0, 2) == 0);
                if (leave && d > 1)
                begin
                    k = $urandom_range(1, d - 1);
                    for (p = 0; p < k; p++)
                        queue_item(OP_COORD, p, pick_value(), 1'($urandom));
                end
            end
            extreme_only = 1'b0;
            ph++;
        end

        if (set_open || vertex_open)
            gen_vertex(1'b1, 1'b0);
        settle();

        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
